@@ rtl/tbp_pkg.sv @@
package tbp_pkg;

    // Fixed field widths of the request and result channels.
    localparam int unsigned NOW_W   = 48;
    localparam int unsigned BYTES_W = 32;
    localparam int unsigned CHUNK_W = 21;

    // Milliseconds in one second: the refill divisor and the full-refill threshold.
    localparam int unsigned MS_PER_SEC = 1000;

    typedef logic [BYTES_W-1:0] bytes_t;
    typedef logic [CHUNK_W-1:0] chunk_t;
    typedef logic [22:0]        rate_q_t;   // rate / 1000
    typedef logic [9:0]         rate_r_t;   // rate % 1000
    typedef logic [9:0]         elapsed_t;  // elapsed time below one second
    typedef logic [19:0]        frac_t;     // elapsed * (rate % 1000)
    typedef logic [1:0]         mode_t;
    typedef logic [1:0]         reg_idx_t;

    // What the bucket stage does with a request.
    localparam mode_t MODE_HOLD  = 2'd0;  // grant with no elapsed time
    localparam mode_t MODE_FILL  = 2'd1;  // first grant, or a second or more gone by
    localparam mode_t MODE_ADD   = 2'd2;  // grant with a partial refill
    localparam mode_t MODE_DEBIT = 2'd3;  // subtract the bytes sent

    // Configuration register indexes.
    localparam reg_idx_t REG_RATE     = 2'd0;
    localparam reg_idx_t REG_CAPACITY = 2'd1;
    localparam reg_idx_t REG_CHUNK    = 2'd2;

    // Register reset values, with the rate already split by 1000.
    localparam bytes_t  RATE_RESET     = 32'd8388608;
    localparam bytes_t  CAPACITY_RESET = 32'd8388608;
    localparam chunk_t  CHUNK_RESET    = 21'd16384;
    localparam rate_q_t RATE_Q_RESET   = 23'd8388;
    localparam rate_r_t RATE_R_RESET   = 10'd608;

    // Division by 1000 is a shift by three and then an exact reciprocal
    // multiplication by ceil(2^36 / 125), valid for every 29-bit dividend.
    localparam logic [29:0] DIV125_MAGIC = 30'd549755814;

    // Request handed from the refill pipeline to the bucket stage.
    typedef struct packed {
        mode_t  mode;
        bytes_t refill;
        bytes_t remaining;
        chunk_t debit;
    } bkt_req_t;

    function automatic rate_q_t div_by_1000(input bytes_t x);
        logic [63:0] prod;
        prod = 64'(x[31:3]) * 64'(DIV125_MAGIC);
        return prod[58:36];
    endfunction

endpackage

@@ rtl/tbp_refill.sv @@
module tbp_refill #(
    parameter int TIME_BITS = 48
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  logic [47:0]             s_now_ms,
    input  tbp_pkg::bytes_t         s_bytes_remaining,
    input  tbp_pkg::chunk_t         s_debit_bytes,
    input  tbp_pkg::rate_q_t        rate_q,
    input  tbp_pkg::rate_r_t        rate_r,
    output logic                    o_valid,
    input  logic                    i_ready,
    output tbp_pkg::bkt_req_t       o_req
);
    import tbp_pkg::*;

    logic [63:0]          now_wide;
    logic [TIME_BITS-1:0] now_in;

    logic                 v0_reg;
    logic                 act0_reg;
    logic [TIME_BITS-1:0] now0_reg;
    bytes_t               rem0_reg;
    chunk_t               deb0_reg;

    logic [TIME_BITS-1:0] last_time_reg;
    logic                 started_reg;

    logic [TIME_BITS-1:0] elapsed;
    logic                 e_zero;
    logic                 e_full;
    elapsed_t             e_ms;
    mode_t                mode0;
    logic [32:0]          whole_prod;
    frac_t                frac_prod;

    logic                 v1_reg;
    mode_t                mode1_reg;
    bytes_t               whole1_reg;
    frac_t                frac1_reg;
    bytes_t               rem1_reg;
    chunk_t               deb1_reg;

    rate_q_t              frac_div;
    logic [32:0]          refill_sum;

    logic                 v2_reg;
    bkt_req_t             req2_reg;

    logic                 ld1;
    logic                 ld2;
    logic                 free1;
    logic                 free2;

    // Stage handshakes: a stage loads when the one ahead is empty or moving on.
    assign free2   = !v2_reg || i_ready;
    assign ld2     = v1_reg && free2;
    assign free1   = !v1_reg || ld2;
    assign ld1     = v0_reg && free1;
    assign s_ready = !v0_reg || ld1;

    // Time is taken modulo 2^TIME_BITS.
    assign now_wide = 64'(s_now_ms);
    assign now_in   = now_wide[TIME_BITS-1:0];

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_ready) begin
            v0_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            act0_reg <= s_action;
            now0_reg <= now_in;
            rem0_reg <= s_bytes_remaining;
            deb0_reg <= s_debit_bytes;
        end
    end

    // Elapsed time and the choice of refill for a grant request.
    assign elapsed = now0_reg - last_time_reg;
    assign e_zero  = (elapsed == '0);
    assign e_full  = (elapsed >= TIME_BITS'(MS_PER_SEC));
    assign e_ms    = elapsed[9:0];

    always_comb begin
        if (act0_reg) begin
            mode0 = MODE_DEBIT;
        end else if (!started_reg || e_full) begin
            mode0 = MODE_FILL;
        end else if (e_zero) begin
            mode0 = MODE_HOLD;
        end else begin
            mode0 = MODE_ADD;
        end
    end

    // With rate = 1000 q + r, the refill is e * q + floor(e * r / 1000).
    assign whole_prod = 33'(e_ms) * 33'(rate_q);
    assign frac_prod  = 20'(e_ms) * 20'(rate_r);

    // The stored time follows every grant that refills the bucket.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            started_reg   <= 1'b0;
        end else if (ld1 && (mode0 == MODE_FILL || mode0 == MODE_ADD)) begin
            last_time_reg <= now0_reg;
            started_reg   <= 1'b1;
        end
    end

    // Product register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (free1) begin
            v1_reg <= v0_reg;
        end
        if (ld1) begin
            mode1_reg  <= mode0;
            whole1_reg <= whole_prod[31:0];
            frac1_reg  <= frac_prod;
            rem1_reg   <= rem0_reg;
            deb1_reg   <= deb0_reg;
        end
    end

    // The sum cannot exceed 999/1000 of a 32-bit rate, so it fits 32 bits.
    assign frac_div   = div_by_1000(32'(frac1_reg));
    assign refill_sum = 33'(whole1_reg) + 33'(frac_div);

    // Refill register, handed to the bucket stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (free2) begin
            v2_reg <= v1_reg;
        end
        if (ld2) begin
            req2_reg.mode      <= mode1_reg;
            req2_reg.refill    <= refill_sum[31:0];
            req2_reg.remaining <= rem1_reg;
            req2_reg.debit     <= deb1_reg;
        end
    end

    assign o_valid = v2_reg;
    assign o_req   = req2_reg;

endmodule

@@ rtl/token_bucket_byte_pacer.sv @@
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  action, now_ms, bytes_remaining, debit_bytes
// m_        out        m_valid / m_ready  grant_bytes, paced, tokens_left, overdraw
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One request is taken every cycle while the result is not stalled; each result
// passes in turn through the input, product and refill registers ahead of the
// bucket update and the result register.
// The bucket level and the stored grant time carry over from one request to the next;
// the level loop closes in a single add, compare and subtract per cycle.
// Reset is synchronous and active low; the bucket starts empty and unused.
// A stalled result holds each stage in turn, and empty stages are filled up.
module token_bucket_byte_pacer #(
    parameter int TIME_BITS = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [47:0]       s_now_ms,
    input  tbp_pkg::bytes_t   s_bytes_remaining,
    input  tbp_pkg::chunk_t   s_debit_bytes,
    output logic              m_valid,
    input  logic              m_ready,
    output tbp_pkg::chunk_t   m_grant_bytes,
    output logic              m_paced,
    output tbp_pkg::bytes_t   m_tokens_left,
    output logic              m_overdraw,
    input  logic              cfg_we,
    input  tbp_pkg::reg_idx_t cfg_index,
    input  tbp_pkg::bytes_t   cfg_wdata
);
    import tbp_pkg::*;

    bytes_t      rate_reg;
    bytes_t      cap_reg;
    chunk_t      chunk_reg;
    rate_q_t     rate_q_reg;
    rate_r_t     rate_r_reg;
    bytes_t      rate_whole;
    bytes_t      rate_rem;

    logic        bkt_valid;
    logic        bkt_ready;
    bkt_req_t    bkt_req;

    bytes_t      token_level_reg;
    logic [32:0] add_sum;
    bytes_t      capped;
    bytes_t      debit_ext;
    bytes_t      chunk_ext;
    bytes_t      level_next;
    logic        over_next;
    logic        paced_next;
    bytes_t      min_rem;
    bytes_t      min_all;
    chunk_t      grant_next;

    logic        m_valid_reg;
    chunk_t      grant_reg;
    logic        paced_reg;
    bytes_t      tokens_reg;
    logic        over_reg;

    // Configuration registers; the rate is split by 1000 as it is written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= RATE_RESET;
            cap_reg    <= CAPACITY_RESET;
            chunk_reg  <= CHUNK_RESET;
            rate_q_reg <= RATE_Q_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RATE: begin
                    rate_reg   <= cfg_wdata;
                    rate_q_reg <= div_by_1000(cfg_wdata);
                end
                REG_CAPACITY: begin
                    cap_reg <= cfg_wdata;
                end
                REG_CHUNK: begin
                    chunk_reg <= cfg_wdata[CHUNK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Remainder of the rate by 1000, registered from the rate and quotient registers after a rate write.
    assign rate_whole = 32'(rate_q_reg) * 32'(MS_PER_SEC);
    assign rate_rem   = rate_reg - rate_whole;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_r_reg <= RATE_R_RESET;
        end else begin
            rate_r_reg <= rate_rem[9:0];
        end
    end

    tbp_refill #(
        .TIME_BITS (TIME_BITS)
    ) u_refill (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_now_ms          (s_now_ms),
        .s_bytes_remaining (s_bytes_remaining),
        .s_debit_bytes     (s_debit_bytes),
        .rate_q            (rate_q_reg),
        .rate_r            (rate_r_reg),
        .o_valid           (bkt_valid),
        .i_ready           (bkt_ready),
        .o_req             (bkt_req)
    );

    assign bkt_ready = !m_valid_reg || m_ready;

    // New bucket level for the request in the refill register.
    assign add_sum   = 33'(token_level_reg) + 33'(bkt_req.refill);
    assign capped    = (add_sum < 33'(cap_reg)) ? add_sum[31:0] : cap_reg;
    assign debit_ext = 32'(bkt_req.debit);

    always_comb begin
        level_next = token_level_reg;
        over_next  = 1'b0;
        case (bkt_req.mode)
            MODE_HOLD: begin
                level_next = token_level_reg;
            end
            MODE_FILL: begin
                level_next = cap_reg;
            end
            MODE_ADD: begin
                level_next = capped;
            end
            MODE_DEBIT: begin
                if (debit_ext > token_level_reg) begin
                    level_next = '0;
                    over_next  = 1'b1;
                end else begin
                    level_next = token_level_reg - debit_ext;
                end
            end
            default: begin
                level_next = token_level_reg;
            end
        endcase
    end

    // For a grant request, the grant is the least of the bytes remaining, the chunk limit and the level.
    assign chunk_ext = 32'(chunk_reg);
    assign min_rem   = (bkt_req.remaining < level_next) ? bkt_req.remaining : level_next;
    assign min_all   = (min_rem < chunk_ext) ? min_rem : chunk_ext;

    always_comb begin
        paced_next = 1'b0;
        grant_next = '0;
        if (bkt_req.mode != MODE_DEBIT) begin
            if (level_next == '0) begin
                paced_next = 1'b1;
            end else begin
                grant_next = min_all[CHUNK_W-1:0];
            end
        end
    end

    // Bucket level, updated as each request enters the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_level_reg <= '0;
        end else if (bkt_valid && bkt_ready) begin
            token_level_reg <= level_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (bkt_ready) begin
            m_valid_reg <= bkt_valid;
        end
        if (bkt_valid && bkt_ready) begin
            grant_reg  <= grant_next;
            paced_reg  <= paced_next;
            tokens_reg <= level_next;
            over_reg   <= over_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_grant_bytes = grant_reg;
    assign m_paced       = paced_reg;
    assign m_tokens_left = tokens_reg;
    assign m_overdraw    = over_reg;

endmodule
